// ===== rtl/core/triac_phase_mode_controller_top_macros.svh =====
// Assertion helpers for the triac phase-mode controller.
// Clocked on i_clk; the first form is disabled while i_rst_n is low.
`ifndef TRIAC_PHASE_MODE_CONTROLLER_TOP_MACROS_SVH
`define TRIAC_PHASE_MODE_CONTROLLER_TOP_MACROS_SVH

`define TPMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpmc: assertion failed");

// Same, but also checked while reset is held.
`define TPMC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tpmc: assertion failed during or after reset");

`endif

// ===== rtl/core/tpmc_pkg.sv =====
package tpmc_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MASK_W    = 4;
    localparam int ANGLE_W   = 8;

    localparam logic [ANGLE_W-1:0] FULL_ANGLE = 8'd180;
    localparam logic [ANGLE_W-1:0] ZERO_ANGLE = 8'd0;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_SYM  = 2'd2,
        MODE_ASYM = 2'd3
    } t_mode;

    typedef struct packed {
        logic               func;
        logic [1:0]         channel;
        logic [ANGLE_W-1:0] pos_angle;
        logic [ANGLE_W-1:0] neg_angle;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic [ANGLE_W-1:0] out_pos;
        logic [ANGLE_W-1:0] out_neg;
        logic [1:0]         new_mode;
        logic               last_command;
    } t_result;

    // work handed from front to back
    typedef struct packed {
        logic                tick;
        logic [CH_IDX_W-1:0] chan;
        logic [ANGLE_W-1:0]  pos;
        logic [ANGLE_W-1:0]  neg;
    } t_cmd;

    // channel exists and its mask bit is set
    function automatic logic chan_en(logic [MASK_W-1:0] mask, int unsigned idx);
        logic r;
        r = 1'b0;
        for (int b = 0; b < MASK_W; b++) begin
            if (idx == b && b < CHANNELS) begin
                r = mask[b];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tpmc_front.sv =====
module tpmc_front
    import tpmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_in_item          i_item,
    input  logic [MASK_W-1:0] i_mask,
    output logic              o_full,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr, r_rd;
    logic [CMDQ_CNT_W-1:0] r_count;

    logic is_tick, keep, do_wr, do_rd;
    t_cmd cmd_new;

    assign o_full      = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd];

    // updates to channels that are off in the mask are dropped here
    always_comb begin
        is_tick      = (i_item.func == FUNC_TICK);
        keep         = is_tick || chan_en(i_mask, int'(i_item.channel));
        cmd_new.tick = is_tick;
        cmd_new.chan = CH_IDX_W'(i_item.channel);
        cmd_new.pos  = i_item.pos_angle;
        cmd_new.neg  = i_item.neg_angle;
        do_wr        = i_push && !o_full && keep;
        do_rd        = i_cmd_pop && o_cmd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_q[r_wr] <= cmd_new;
                r_wr <= (r_wr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tpmc_back.sv =====
module tpmc_back
    import tpmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MASK_W-1:0] i_mask,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_outq_full,
    output logic              o_res_push,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state              r_state;
    logic [CH_IDX_W-1:0] r_scan;
    logic                r_hold_valid;
    t_result             r_hold;

    t_mode               r_mode [CHANNELS];
    logic [ANGLE_W-1:0]  r_pos  [CHANNELS];
    logic [ANGLE_W-1:0]  r_neg  [CHANNELS];
    logic                r_ref  [CHANNELS];

    logic               en, emit, clr_ref, stall, is_off, is_on, mid;
    t_mode              m, n_mode;
    logic [ANGLE_W-1:0] p, n, n_pos, n_neg;
    t_result            res_new;

    // transition rules for the channel under the scan pointer
    always_comb begin
        en      = chan_en(i_mask, int'(r_scan));
        m       = r_mode[r_scan];
        p       = r_pos[r_scan];
        n       = r_neg[r_scan];
        is_off  = (p == ZERO_ANGLE) && (n == ZERO_ANGLE);
        is_on   = (p == FULL_ANGLE) && (n == FULL_ANGLE);
        mid     = (p != ZERO_ANGLE) && (p < FULL_ANGLE);
        emit    = 1'b0;
        clr_ref = 1'b0;
        n_mode  = m;
        n_pos   = p;
        n_neg   = n;
        if (en) begin
            priority if (m != MODE_OFF && is_off) begin
                emit   = 1'b1;
                n_mode = MODE_OFF;
                n_pos  = ZERO_ANGLE;
                n_neg  = ZERO_ANGLE;
            end else if (m != MODE_ON && is_on) begin
                emit   = 1'b1;
                n_mode = MODE_ON;
                n_pos  = FULL_ANGLE;
                n_neg  = FULL_ANGLE;
            end else if (m == MODE_OFF || m == MODE_ON) begin
                if (mid) begin
                    emit   = 1'b1;
                    n_mode = (p == n) ? MODE_SYM : MODE_ASYM;
                end
            end else if (m == MODE_SYM) begin
                if (p != n) begin
                    emit   = 1'b1;
                    n_mode = MODE_ASYM;
                end else if (r_ref[r_scan]) begin
                    emit    = 1'b1;
                    clr_ref = 1'b1;
                end
            end else begin
                if (p == n) begin
                    emit   = 1'b1;
                    n_mode = MODE_SYM;
                end else if (r_ref[r_scan]) begin
                    emit    = 1'b1;
                    clr_ref = 1'b1;
                end
            end
        end
        res_new.out_channel  = 2'(r_scan);
        res_new.out_pos      = n_pos;
        res_new.out_neg      = n_neg;
        res_new.new_mode     = 2'(n_mode);
        res_new.last_command = 1'b0;

        // a held command leaves only once a later one (or the tick's end) shows up
        stall      = emit && r_hold_valid && i_outq_full;
        o_res      = r_hold;
        o_res_push = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                o_res_push = emit && r_hold_valid && !i_outq_full;
            end
            S_FLUSH: begin
                o_res_push         = r_hold_valid && !i_outq_full;
                o_res.last_command = 1'b1;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scan       <= '0;
            r_hold_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_mode[c] <= MODE_OFF;
                r_pos[c]  <= ZERO_ANGLE;
                r_neg[c]  <= ZERO_ANGLE;
                r_ref[c]  <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.tick) begin
                            r_state <= S_SCAN;
                            r_scan  <= '0;
                        end else begin
                            r_pos[i_cmd.chan] <= i_cmd.pos;
                            r_neg[i_cmd.chan] <= i_cmd.neg;
                            r_ref[i_cmd.chan] <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        if (emit) begin
                            r_hold       <= res_new;
                            r_hold_valid <= 1'b1;
                            r_mode[r_scan] <= n_mode;
                            r_pos[r_scan]  <= n_pos;
                            r_neg[r_scan]  <= n_neg;
                            if (clr_ref) begin
                                r_ref[r_scan] <= 1'b0;
                            end
                        end
                        if (r_scan == CH_IDX_W'(CHANNELS - 1)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_scan <= r_scan + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_valid) begin
                        r_state <= S_IDLE;
                    end else if (!i_outq_full) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/tpmc_outq.sv =====
module tpmc_outq
    import tpmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    t_result               r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr, r_rd;
    logic [OUTQ_CNT_W-1:0] r_count;
    logic                  do_wr, do_rd;

    assign o_full  = (r_count == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_res   = r_q[r_rd];
    assign do_wr   = i_push && !o_full;
    assign do_rd   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_q[r_wr] <= i_res;
                r_wr <= (r_wr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/triac_phase_mode_controller_top.sv =====
// Triac phase-mode controller. Keeps a mode, two firing angles and a refresh flag
// per channel. An update transaction (func = 0) stores a channel's angles and flags
// it for refresh; it is dropped when the channel is not set in the enable mask. A
// tick transaction (func = 1) walks the enabled channels in ascending order and
// pushes one drive command per channel that changes mode or needs a refresh; the
// final command of a tick carries last_command = 1, a tick with nothing to do gives
// none. Input side is a queue port (push/full), results are read as a queue
// (empty/pop). The enable mask is written over its own valid/ready channel, which is
// always ready; the user must write it only while the block is quiet, and the block
// does not enforce this. The execution unit stores an update from idle; a tick
// starts, scans each channel in turn, then releases the final command, and stalls
// while the result queue is full. The scan of one channel per cycle sets the rate
// while the result queue has room. A two-entry command queue lets new transactions
// be taken during a tick, and a four-entry result queue decouples the reader.
module triac_phase_mode_controller_top
    import tpmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              push,
    output logic              full,
    input  t_in_item          i_item,
    // results
    output logic              empty,
    input  logic              pop,
    output t_result           o_result,
    // enable mask write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data
);

    logic [MASK_W-1:0] r_mask;

    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    logic    res_push, outq_full;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    // front: take and classify, buffer commands
    tpmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_mask      (r_mask),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: channel state, scan and mode rules
    tpmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask      (r_mask),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_outq_full (outq_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // result queue towards the reader
    tpmc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (outq_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_result)
    );

endmodule

// ===== rtl/core/tpmc_checker.sv =====
`include "triac_phase_mode_controller_top_macros.svh"

module tpmc_checker
    import tpmc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    t_mode res_mode;
    logic  both_full, both_zero, angles_match, is_phase;

    assign res_mode     = t_mode'(o_result.new_mode);
    assign both_full    = (o_result.out_pos == FULL_ANGLE) && (o_result.out_neg == FULL_ANGLE);
    assign both_zero    = (o_result.out_pos == ZERO_ANGLE) && (o_result.out_neg == ZERO_ANGLE);
    assign angles_match = (o_result.out_pos == o_result.out_neg);
    assign is_phase     = o_result.new_mode[1];

    // reset leaves no command waiting
    `TPMC_ASSERT_RST(a_empty_after_rst, !i_rst_n |=> empty)

    // a command not taken stays put
    `TPMC_ASSERT(a_res_hold, !empty && !pop |=> !empty && $stable(o_result))

    // entering on drives full angle both halves
    `TPMC_ASSERT(a_on_angles, !empty && res_mode == MODE_ON |-> both_full)

    // entering off drives zero both halves
    `TPMC_ASSERT(a_off_angles, !empty && res_mode == MODE_OFF |-> both_zero)

    // phase commands: symmetric exactly when the two angles match
    `TPMC_ASSERT(a_phase_angles, !empty && is_phase |-> angles_match == (res_mode == MODE_SYM))

endmodule

bind triac_phase_mode_controller_top tpmc_checker u_tpmc_checker (.*);
